// ===== sv/crf_pkg.sv =====
// Shared types and constants for the checksummed frame receiver.
// Used by every module of the block; depends on nothing.
package crf_pkg;

  localparam logic [7:0] HEADER_BYTE       = 8'hFF;
  localparam logic [7:0] LENGTH_OVERHEAD   = 8'd2;
  localparam logic [7:0] REPLY_HEADER_RST  = 8'd251;
  localparam logic [7:0] MAX_DATA_CNT_RST  = 8'd200;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_CSUM_ERR = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_REPLY_HEADER = 1'b0,
    CFG_MAX_DATA_CNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] frame_type;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       last;
  } result_t;

endpackage

// ===== sv/checksummed_frame_receiver.sv =====
// Top level of the checksummed frame receiver: input register, configuration
// registers, deframer and result register. Depends on crf_pkg and all crf_ modules.
//
//  channel | direction | payload
//  in_     | slave     | tdata[7:0] rx_byte
//  out_    | master    | tdata frame_type/payload_byte/payload_index, tuser kind, tlast
//  cfg_    | slave     | cfg_index register, cfg_data value
//
// One byte is taken per cycle while no held result stalls; each byte is registered in
// the input register, and its result, if any, is loaded into the result register.
// Reset clears the parser to the header hunt and loads the register defaults.
// A held result stalls the parser only while out_tready is low.
module checksummed_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] frame_type, [15:8] payload_byte, [23:16] payload_index
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import crf_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic [7:0] reply_header_r;
  logic [7:0] max_data_cnt_r;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_header_r <= REPLY_HEADER_RST;
      max_data_cnt_r <= MAX_DATA_CNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_REPLY_HEADER: reply_header_r <= cfg_data;
        CFG_MAX_DATA_CNT: max_data_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  crf_deframer u_deframer (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .rx_byte      (in_byte_r),
    .reply_header (reply_header_r),
    .max_data_cnt (max_data_cnt_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  crf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .load_data (res),
    .take      (out_tready),
    .valid     (out_tvalid),
    .data      (out_data)
  );

  assign out_tdata = {out_data.payload_index, out_data.payload_byte, out_data.frame_type};
  assign out_tuser = out_data.kind;
  assign out_tlast = out_data.last;

endmodule

// ===== sv/crf_deframer.sv =====
// Frame parsing state machine with the running 8-bit checksum.
// Depends on crf_pkg; one received byte is consumed per enabled cycle.
module crf_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          reply_header,
  input  logic [7:0]          max_data_cnt,
  output logic                res_valid,
  output crf_pkg::result_t    res
);
  import crf_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] position_r, position_nxt;
  logic [7:0] data_cnt;

  assign data_cnt = length_r - LENGTH_OVERHEAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      length_r   <= '0;
      type_r     <= '0;
      sum_r      <= '0;
      remain_r   <= '0;
      position_r <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      length_r   <= length_nxt;
      type_r     <= type_nxt;
      sum_r      <= sum_nxt;
      remain_r   <= remain_nxt;
      position_r <= position_nxt;
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    length_nxt        = length_r;
    type_nxt          = type_r;
    sum_nxt           = sum_r;
    remain_nxt        = remain_r;
    position_nxt      = position_r;
    res_valid         = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.frame_type    = type_r;
    res.payload_byte  = '0;
    res.payload_index = position_r;
    res.last          = 1'b0;
    unique case (phase_r)
      PH_HEAD2: begin
        phase_nxt = (rx_byte == reply_header) ? PH_LEN : PH_HUNT;
      end
      PH_LEN: begin
        length_nxt = rx_byte;
        phase_nxt  = PH_TYPE;
      end
      PH_TYPE: begin
        type_nxt = rx_byte;
        if (length_r <= LENGTH_OVERHEAD || data_cnt > max_data_cnt) begin
          phase_nxt = PH_HUNT;
        end else begin
          remain_nxt   = data_cnt;
          sum_nxt      = length_r + rx_byte;
          position_nxt = '0;
          phase_nxt    = PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid = 1'b1;
        if (remain_r <= 8'd1) begin
          res.kind   = (sum_r == rx_byte) ? KIND_GOOD : KIND_CSUM_ERR;
          res.last   = 1'b1;
          remain_nxt = '0;
          phase_nxt  = PH_HUNT;
        end else begin
          res.payload_byte = rx_byte;
          sum_nxt          = sum_r + rx_byte;
          position_nxt     = position_r + 8'd1;
          remain_nxt       = remain_r - 8'd1;
        end
      end
      default: begin
        phase_nxt = (rx_byte == HEADER_BYTE) ? PH_HEAD2 : PH_HUNT;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_data_has_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> remain_r != 8'd0)
    else $error("Payload phase entered with no bytes remaining.");

  a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid && res.last |=> phase_r == PH_HUNT)
    else $error("Frame end did not restart the header hunt.");

  a_short_length_abandons: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && phase_r == PH_TYPE && length_r <= LENGTH_OVERHEAD |=> phase_r == PH_HUNT)
    else $error("A frame with a short length was not abandoned.");

  a_position_advances: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid && !res.last |=> position_r == $past(position_r) + 8'd1)
    else $error("Payload position did not advance on a payload byte.");
`endif

endmodule

// ===== sv/crf_out_reg.sv =====
// Result register that holds one result until the downstream transfer.
// Depends on crf_pkg for the result structure.
module crf_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  crf_pkg::result_t load_data,
  input  logic             take,
  output logic             valid,
  output crf_pkg::result_t data
);
  import crf_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  always_comb begin
    priority if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule
